// ===== design/ets_pkg.sv =====
// ets_pkg: shared types, constants and helper functions of the expression token scanner
// used by ets_out_if and by expression_token_scanner
package ets_pkg;

  // internal counter widths and width of the position and line fields on the ports
  localparam int PosWidth    = 16;
  localparam int LineWidth   = 16;
  localparam int FieldWidth  = 16;
  localparam int KindWidth   = 5;
  localparam int ErrWidth    = 3;

  // spaces that make up one tab token
  localparam int SpacesPerTab = 4;
  localparam int RunWidth     = $clog2(SpacesPerTab);

  // decimal separator after reset ('.')
  localparam logic [7:0] SepReset = 8'd46;

  // character codes
  localparam logic [7:0] ChTab        = 8'h09;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChBang       = 8'h21;
  localparam logic [7:0] ChQuote      = 8'h22;
  localparam logic [7:0] ChHash       = 8'h23;
  localparam logic [7:0] ChLparen     = 8'h28;
  localparam logic [7:0] ChRparen     = 8'h29;
  localparam logic [7:0] ChStar       = 8'h2A;
  localparam logic [7:0] ChPlus       = 8'h2B;
  localparam logic [7:0] ChComma      = 8'h2C;
  localparam logic [7:0] ChMinus      = 8'h2D;
  localparam logic [7:0] ChDot        = 8'h2E;
  localparam logic [7:0] ChSlash      = 8'h2F;
  localparam logic [7:0] ChDigit0     = 8'h30;
  localparam logic [7:0] ChDigit9     = 8'h39;
  localparam logic [7:0] ChColon      = 8'h3A;
  localparam logic [7:0] ChSemi       = 8'h3B;
  localparam logic [7:0] ChLess       = 8'h3C;
  localparam logic [7:0] ChEqual      = 8'h3D;
  localparam logic [7:0] ChGreater    = 8'h3E;
  localparam logic [7:0] ChUpperA     = 8'h41;
  localparam logic [7:0] ChUpperZ     = 8'h5A;
  localparam logic [7:0] ChCaret      = 8'h5E;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChLowerA     = 8'h61;
  localparam logic [7:0] ChLowerZ     = 8'h7A;

  // token kinds
  typedef enum logic [KindWidth-1:0] {
    KindLparen       = 5'd0,
    KindRparen       = 5'd1,
    KindComma        = 5'd2,
    KindDot          = 5'd3,
    KindMinus        = 5'd4,
    KindPlus         = 5'd5,
    KindSemicolon    = 5'd6,
    KindStar         = 5'd7,
    KindColon        = 5'd8,
    KindColonEquals  = 5'd9,
    KindSlash        = 5'd10,
    KindSlashEquals  = 5'd11,
    KindBang         = 5'd12,
    KindBangEquals   = 5'd13,
    KindEqual        = 5'd14,
    KindEqualEqual   = 5'd15,
    KindLess         = 5'd16,
    KindLessEqual    = 5'd17,
    KindGreater      = 5'd18,
    KindGreaterEqual = 5'd19,
    KindExponent     = 5'd20,
    KindTab          = 5'd21,
    KindString       = 5'd22,
    KindInteger      = 5'd23,
    KindDecimal      = 5'd24,
    KindIdentifier   = 5'd25,
    KindEof          = 5'd26
  } kind_e;

  // error codes
  typedef enum logic [ErrWidth-1:0] {
    ErrNone         = 3'd0,
    ErrUnexpected   = 3'd1,
    ErrUnterminated = 3'd2,
    ErrDangling     = 3'd3,
    ErrOverflow     = 3'd4
  } err_e;

  // one result item as held in the output queue
  typedef struct packed {
    logic [KindWidth-1:0]  token_kind;
    logic [FieldWidth-1:0] start_pos;
    logic [FieldWidth-1:0] end_pos;
    logic [FieldWidth-1:0] line_number;
    logic [ErrWidth-1:0]   error_code;
    logic                  last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= ChDigit0) && (c <= ChDigit9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= ChLowerA) && (c <= ChLowerZ)) ||
               ((c >= ChUpperA) && (c <= ChUpperZ)) || (c == ChUnderscore);
  endfunction

  // single form of an operator that may take a trailing '='
  function automatic kind_e pair_kind(input logic [7:0] c);
    case (c)
      ChColon:   pair_kind = KindColon;
      ChSlash:   pair_kind = KindSlash;
      ChBang:    pair_kind = KindBang;
      ChLess:    pair_kind = KindLess;
      ChGreater: pair_kind = KindGreater;
      default:   pair_kind = KindEqual;
    endcase
  endfunction

  // token result, last set on end of file
  function automatic result_t make_token(input kind_e k, input logic [PosWidth-1:0] s,
                                         input logic [PosWidth-1:0] e,
                                         input logic [LineWidth-1:0] ln);
    make_token.token_kind  = k;
    make_token.start_pos   = FieldWidth'(s);
    make_token.end_pos     = FieldWidth'(e);
    make_token.line_number = FieldWidth'(ln);
    make_token.error_code  = ErrNone;
    make_token.last        = (k == KindEof);
  endfunction

  // error result, kind zero and last set
  function automatic result_t make_error(input err_e er, input logic [PosWidth-1:0] s,
                                         input logic [PosWidth-1:0] e,
                                         input logic [LineWidth-1:0] ln);
    make_error.token_kind  = KindLparen;
    make_error.start_pos   = FieldWidth'(s);
    make_error.end_pos     = FieldWidth'(e);
    make_error.line_number = FieldWidth'(ln);
    make_error.error_code  = er;
    make_error.last        = 1'b1;
  endfunction

endpackage

// ===== design/ets_in_if.sv =====
// ets_in_if: source byte channel of the expression token scanner
// depends on nothing
interface ets_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_source;

  modport source (output valid, output char_code, output end_of_source, input ready);
  modport sink   (input valid, input char_code, input end_of_source, output ready);
endinterface

// ===== design/ets_out_if.sv =====
// ets_out_if: token result channel of the expression token scanner
// depends on ets_pkg for field widths
interface ets_out_if;
  logic                          valid;
  logic                          ready;
  logic [ets_pkg::KindWidth-1:0]  token_kind;
  logic [ets_pkg::FieldWidth-1:0] start_pos;
  logic [ets_pkg::FieldWidth-1:0] end_pos;
  logic [ets_pkg::FieldWidth-1:0] line_number;
  logic [ets_pkg::ErrWidth-1:0]   error_code;
  logic                          last;

  modport source (output valid, output token_kind, output start_pos, output end_pos,
                  output line_number, output error_code, output last, input ready);
  modport sink   (input valid, input token_kind, input start_pos, input end_pos,
                  input line_number, input error_code, input last, output ready);
endinterface

// ===== design/ets_cfg_if.sv =====
// ets_cfg_if: configuration write channel carrying the decimal separator
// depends on nothing
interface ets_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] decimal_separator;

  modport source (output valid, output decimal_separator, input ready);
  modport sink   (input valid, input decimal_separator, output ready);
endinterface

// ===== design/expression_token_scanner.sv =====
// expression_token_scanner: streaming lexical scanner, one source byte per transfer
// depends on ets_pkg, ets_in_if, ets_out_if and ets_cfg_if
//
// Usage:
//   in_ch carries one source byte per transfer, end_of_source on the final byte.
//   out_ch carries tokens (kind, start/end position, line, error code, last).
//   cfg_ch writes the decimal separator; it is always ready. The user must write it only
//   while no byte is in flight and all tokens have been taken; the block does not enforce it.
// Timing:
//   a byte is decoded in the cycle it is transferred; its tokens (zero to three)
//   sit in a four-entry result queue and the first is offered on the next cycle.
//   One byte per cycle is taken while the queue holds at most one token, so a
//   byte with one token or none sustains one byte per cycle while out_ch is ready;
//   after a byte that makes two or three tokens, in_ch waits while the single
//   queue read port drains the queue to one token.
// Reset: scan state, positions and line count clear, the separator returns to
//   '.', the queue empties. After the final byte of a source the scan state
//   clears again and the separator is kept.
// Stall: when out_ch is not ready the queue fills; in_ch drops ready once more
//   than one token is waiting, and no token is lost or reordered.
module expression_token_scanner (
  input  logic     clk_i,
  input  logic     rst_ni,
  ets_in_if.sink   in_ch,
  ets_out_if.source out_ch,
  ets_cfg_if.sink  cfg_ch
);

  typedef enum logic [3:0] {
    ModeIdle,
    ModeComment,
    ModePair,
    ModeSpace,
    ModeString,
    ModeInt,
    ModeSep,
    ModeFrac,
    ModeIdent
  } mode_e;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);
  localparam int NCand  = 4;

  // scan state
  mode_e                         mode_q, mode_d;
  logic [7:0]                    pend_q, pend_d;
  logic [ets_pkg::PosWidth-1:0]  start_q, start_d;
  logic [ets_pkg::PosWidth-1:0]  idx_q, idx_d;
  logic [ets_pkg::LineWidth-1:0] line_q, line_d;
  logic [ets_pkg::RunWidth-1:0]  run_q, run_d;
  logic                          halt_q, halt_d;
  logic [7:0]                    sep_q;

  // result queue
  ets_pkg::result_t              queue_q [QDepth];
  logic [QPtrW-1:0]              rd_q, wr_q;
  logic [QCntW-1:0]              cnt_q;

  // decode outputs
  ets_pkg::result_t              cand [NCand];
  logic [NCand-1:0]              cand_v;
  logic [QPtrW-1:0]              cand_off [NCand];
  logic [QCntW-1:0]              n_new;

  logic [7:0]                    c;
  logic                          fin;
  logic                          fail;
  logic                          do_begin;
  logic [ets_pkg::PosWidth-1:0]  nidx;
  logic                          in_fire, out_fire, cfg_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;

  assign c    = in_ch.char_code;
  assign fin  = in_ch.end_of_source;
  assign nidx = idx_q + 1'b1;

  // byte decode: feed, begin, finish and end of file
  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    start_d  = start_q;
    idx_d    = idx_q;
    line_d   = line_q;
    run_d    = run_q;
    halt_d   = halt_q;
    fail     = 1'b0;
    do_begin = 1'b0;
    cand_v   = '0;
    for (int k = 0; k < NCand; k++) begin
      cand[k] = '0;
    end

    if (halt_q) begin
      // ignore bytes until the source ends
    end else if (&idx_q) begin
      cand_v[0] = 1'b1;
      cand[0]   = ets_pkg::make_error(ets_pkg::ErrOverflow, idx_q, idx_q, line_q);
      fail      = 1'b1;
    end else begin
      idx_d = nidx;

      // continue or close the open token
      case (mode_q)
        ModeComment: begin
          if (c == ets_pkg::ChNewline) do_begin = 1'b1;
        end
        ModePair: begin
          cand_v[0] = 1'b1;
          if (c == ets_pkg::ChEqual) begin
            cand[0] = ets_pkg::make_token(
                ets_pkg::kind_e'(ets_pkg::pair_kind(pend_q) + 5'd1), start_q, nidx, line_q);
            mode_d  = ModeIdle;
          end else begin
            cand[0]  = ets_pkg::make_token(ets_pkg::pair_kind(pend_q), start_q, idx_q, line_q);
            do_begin = 1'b1;
          end
        end
        ModeSpace: begin
          if (c == ets_pkg::ChSpace) begin
            if (run_q == ets_pkg::RunWidth'(ets_pkg::SpacesPerTab - 1)) begin
              cand_v[0] = 1'b1;
              cand[0]   = ets_pkg::make_token(ets_pkg::KindTab, start_q, nidx, line_q);
              mode_d    = ModeIdle;
              run_d     = '0;
            end else begin
              run_d = run_q + 1'b1;
            end
          end else begin
            run_d    = '0;
            do_begin = 1'b1;
          end
        end
        ModeString: begin
          if (c == ets_pkg::ChQuote) begin
            cand_v[0] = 1'b1;
            cand[0]   = ets_pkg::make_token(ets_pkg::KindString, start_q + 1'b1, idx_q,
                                            line_q);
            mode_d    = ModeIdle;
          end else if (c == ets_pkg::ChNewline) begin
            if (&line_q) begin
              cand_v[0] = 1'b1;
              cand[0]   = ets_pkg::make_error(ets_pkg::ErrOverflow, idx_q, nidx, line_q);
              fail      = 1'b1;
            end else begin
              line_d = line_q + 1'b1;
            end
          end
        end
        ModeInt: begin
          if (ets_pkg::is_digit(c)) begin
            // stay in the integer part
          end else if (c == sep_q) begin
            mode_d = ModeSep;
          end else begin
            cand_v[0] = 1'b1;
            cand[0]   = ets_pkg::make_token(ets_pkg::KindInteger, start_q, idx_q, line_q);
            do_begin  = 1'b1;
          end
        end
        ModeSep: begin
          if (ets_pkg::is_digit(c)) begin
            mode_d = ModeFrac;
          end else begin
            cand_v[0] = 1'b1;
            cand[0]   = ets_pkg::make_error(ets_pkg::ErrDangling, start_q, idx_q, line_q);
            fail      = 1'b1;
          end
        end
        ModeFrac: begin
          if (!ets_pkg::is_digit(c)) begin
            cand_v[0] = 1'b1;
            cand[0]   = ets_pkg::make_token(ets_pkg::KindDecimal, start_q, idx_q, line_q);
            do_begin  = 1'b1;
          end
        end
        ModeIdent: begin
          if (!(ets_pkg::is_digit(c) || ets_pkg::is_alpha(c))) begin
            cand_v[0] = 1'b1;
            cand[0]   = ets_pkg::make_token(ets_pkg::KindIdentifier, start_q, idx_q, line_q);
            do_begin  = 1'b1;
          end
        end
        default: begin
          do_begin = 1'b1;
        end
      endcase

      // start a new token with this byte
      if (do_begin) begin
        mode_d  = ModeIdle;
        start_d = idx_q;
        case (c)
          ets_pkg::ChLparen: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindLparen, idx_q, nidx, line_q);
          end
          ets_pkg::ChRparen: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindRparen, idx_q, nidx, line_q);
          end
          ets_pkg::ChComma: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindComma, idx_q, nidx, line_q);
          end
          ets_pkg::ChDot: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindDot, idx_q, nidx, line_q);
          end
          ets_pkg::ChMinus: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindMinus, idx_q, nidx, line_q);
          end
          ets_pkg::ChPlus: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindPlus, idx_q, nidx, line_q);
          end
          ets_pkg::ChSemi: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindSemicolon, idx_q, nidx, line_q);
          end
          ets_pkg::ChStar: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindStar, idx_q, nidx, line_q);
          end
          ets_pkg::ChCaret: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindExponent, idx_q, nidx, line_q);
          end
          ets_pkg::ChColon, ets_pkg::ChSlash, ets_pkg::ChBang, ets_pkg::ChEqual,
          ets_pkg::ChLess, ets_pkg::ChGreater: begin
            pend_d = c;
            mode_d = ModePair;
          end
          ets_pkg::ChHash: begin
            mode_d = ModeComment;
          end
          ets_pkg::ChCr: begin
            // carriage return is silent
          end
          ets_pkg::ChTab: begin
            cand_v[1] = 1'b1;
            cand[1]   = ets_pkg::make_token(ets_pkg::KindTab, idx_q, nidx, line_q);
          end
          ets_pkg::ChSpace: begin
            mode_d = ModeSpace;
            run_d  = ets_pkg::RunWidth'(1);
          end
          ets_pkg::ChQuote: begin
            mode_d = ModeString;
          end
          ets_pkg::ChNewline: begin
            if (&line_q) begin
              cand_v[1] = 1'b1;
              cand[1]   = ets_pkg::make_error(ets_pkg::ErrOverflow, idx_q, nidx, line_q);
              fail      = 1'b1;
            end else begin
              line_d = line_q + 1'b1;
            end
          end
          default: begin
            if (ets_pkg::is_digit(c)) begin
              mode_d = ModeInt;
            end else if (ets_pkg::is_alpha(c)) begin
              mode_d = ModeIdent;
            end else begin
              cand_v[1] = 1'b1;
              cand[1]   = ets_pkg::make_error(ets_pkg::ErrUnexpected, idx_q, nidx, line_q);
              fail      = 1'b1;
            end
          end
        endcase
      end

      // flush the open token at the end of the source
      if (fin && !fail) begin
        case (mode_d)
          ModePair: begin
            cand_v[2] = 1'b1;
            cand[2]   = ets_pkg::make_token(ets_pkg::pair_kind(pend_d), start_d, nidx, line_d);
          end
          ModeString: begin
            cand_v[2] = 1'b1;
            cand[2]   = ets_pkg::make_error(ets_pkg::ErrUnterminated, start_d, nidx, line_d);
            fail      = 1'b1;
          end
          ModeInt: begin
            cand_v[2] = 1'b1;
            cand[2]   = ets_pkg::make_token(ets_pkg::KindInteger, start_d, nidx, line_d);
          end
          ModeSep: begin
            cand_v[2] = 1'b1;
            cand[2]   = ets_pkg::make_error(ets_pkg::ErrDangling, start_d, nidx, line_d);
            fail      = 1'b1;
          end
          ModeFrac: begin
            cand_v[2] = 1'b1;
            cand[2]   = ets_pkg::make_token(ets_pkg::KindDecimal, start_d, nidx, line_d);
          end
          ModeIdent: begin
            cand_v[2] = 1'b1;
            cand[2]   = ets_pkg::make_token(ets_pkg::KindIdentifier, start_d, nidx, line_d);
          end
          default: begin
          end
        endcase
      end

      // end of file token
      if (fin && !fail) begin
        cand_v[3] = 1'b1;
        cand[3]   = ets_pkg::make_token(ets_pkg::KindEof, nidx, nidx, line_d);
      end
    end

    if (fail) halt_d = 1'b1;

    // new source after the final byte
    if (fin) begin
      mode_d  = ModeIdle;
      pend_d  = '0;
      start_d = '0;
      idx_d   = '0;
      line_d  = '0;
      run_d   = '0;
      halt_d  = 1'b0;
    end
  end

  // queue slot of each candidate, packed in order
  always_comb begin
    cand_off[0] = '0;
    for (int k = 1; k < NCand; k++) begin
      cand_off[k] = cand_off[k-1] + QPtrW'(cand_v[k-1]);
    end
    n_new = QCntW'(cand_off[NCand-1]) + QCntW'(cand_v[NCand-1]);
  end

  // scan state and separator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      pend_q  <= '0;
      start_q <= '0;
      idx_q   <= '0;
      line_q  <= '0;
      run_q   <= '0;
      halt_q  <= 1'b0;
      sep_q   <= ets_pkg::SepReset;
    end else begin
      if (in_fire) begin
        mode_q  <= mode_d;
        pend_q  <= pend_d;
        start_q <= start_d;
        idx_q   <= idx_d;
        line_q  <= line_d;
        run_q   <= run_d;
        halt_q  <= halt_d;
      end
      if (cfg_fire) sep_q <= cfg_ch.decimal_separator;
    end
  end

  // result queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_fire) wr_q <= wr_q + QPtrW'(n_new);
      if (out_fire) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (in_fire ? n_new : '0) - QCntW'(out_fire);
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NCand; k++) begin
      if (in_fire && cand_v[k]) queue_q[wr_q + cand_off[k]] <= cand[k];
    end
  end

  // channel outputs
  assign in_ch.ready        = (cnt_q <= QCntW'(1));
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = (cnt_q != '0);
  assign out_ch.token_kind  = queue_q[rd_q].token_kind;
  assign out_ch.start_pos   = queue_q[rd_q].start_pos;
  assign out_ch.end_pos     = queue_q[rd_q].end_pos;
  assign out_ch.line_number = queue_q[rd_q].line_number;
  assign out_ch.error_code  = queue_q[rd_q].error_code;
  assign out_ch.last        = queue_q[rd_q].last;

  // queue never overruns
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overrun");

  // a halted scanner adds no results
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && halt_q) |=> (cnt_q <= $past(cnt_q)))
    else $error("result produced while halted");

  // error results carry kind zero and last
  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.error_code != ets_pkg::ErrNone)) |->
      (out_ch.last && (out_ch.token_kind == ets_pkg::KindLparen)))
    else $error("malformed error result");

  // final byte returns the scan to its start
  a_source_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && fin) |=> ((idx_q == '0) && (line_q == '0) && !halt_q && (mode_q == ModeIdle)))
    else $error("scan state not cleared after final byte");

endmodule
